// File: hw/rtl/sst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg: shared types and lookup table for the syllabic script transliterator
// Lookup table of code points, character classes and result buffer types.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CpW    = 21;
    localparam int MaxRes = 12;
    localparam int CntW   = 4;

    typedef enum logic [2:0] {
        K_PLAIN   = 3'd0,
        K_PUNCT   = 3'd1,
        K_CONS    = 3'd2,
        K_SUB     = 3'd3,
        K_VOWEL   = 3'd4,
        K_MARK    = 3'd5,
        K_CARRIER = 3'd6,
        K_UNKNOWN = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [CpW-1:0]   c0;
        logic [CpW-1:0]   c1;
    } map_t;

    // One input's worth of results, queued between front and back.
    typedef struct packed {
        logic [CntW-1:0]             n;
        logic [MaxRes-1:0][CpW-1:0]  ch;
    } burst_t;

    localparam logic [3:0] P_NONE = 4'd0;
    localparam logic [3:0] P_AA   = 4'd9;

    function automatic map_t m(input kind_t k, input int a, input int b);
        map_t r;
        r.kind = k;
        r.c0   = CpW'(a);
        r.c1   = CpW'(b);
        return r;
    endfunction

    function automatic map_t lookup(input logic [CpW-1:0] x);
        map_t r;
        r = m(K_UNKNOWN, 0, 0);
        case (x)
            21'h20:  r = m(K_PLAIN, 32'h20, 0);
            21'hF00: r = m(K_PLAIN, 32'h6F, 32'h1E43);
            21'h0A:  r = m(K_PUNCT, 32'h0A, 0);
            21'hF0B: r = m(K_PUNCT, 32'h2D, 0);
            21'hF0D: r = m(K_PUNCT, 32'h7C, 32'h0A);
            21'hF14: r = m(K_PUNCT, 32'h3B, 0);
            21'hF40: r = m(K_CONS, "k", 0);
            21'hF41: r = m(K_CONS, "k", "h");
            21'hF42: r = m(K_CONS, "g", 0);
            21'hF43: r = m(K_CONS, "g", "h");
            21'hF44: r = m(K_CONS, 32'h1E45, 0);
            21'hF45: r = m(K_CONS, "c", 0);
            21'hF59: r = m(K_CONS, "c", 0);
            21'hF46: r = m(K_CONS, "c", "h");
            21'hF5A: r = m(K_CONS, "c", "h");
            21'hF5B: r = m(K_CONS, "j", 0);
            21'hF5C: r = m(K_CONS, "j", "h");
            21'hF49: r = m(K_CONS, 32'hF1, 0);
            21'hF4A: r = m(K_CONS, 32'h1E6D, 0);
            21'hF4B: r = m(K_CONS, 32'h1E6D, "h");
            21'hF4C: r = m(K_CONS, 32'h1E0D, 0);
            21'hF4D: r = m(K_CONS, 32'h1E0D, "h");
            21'hF4E: r = m(K_CONS, 32'h1E47, 0);
            21'hF4F: r = m(K_CONS, "t", 0);
            21'hF50: r = m(K_CONS, "t", "h");
            21'hF51: r = m(K_CONS, "d", 0);
            21'hF52: r = m(K_CONS, "d", "h");
            21'hF53: r = m(K_CONS, "n", 0);
            21'hF54: r = m(K_CONS, "p", 0);
            21'hF55: r = m(K_CONS, "p", "h");
            21'hF56: r = m(K_CONS, "b", 0);
            21'hF57: r = m(K_CONS, "b", "h");
            21'hF58: r = m(K_CONS, "m", 0);
            21'hF61: r = m(K_CONS, "y", 0);
            21'hF5D: r = m(K_CONS, "v", 0);
            21'hF64: r = m(K_CONS, 32'h15B, 0);
            21'hF65: r = m(K_CONS, 32'h1E63, 0);
            21'hF66: r = m(K_CONS, "s", 0);
            21'hF67: r = m(K_CONS, "h", 0);
            21'hF68: r = m(K_CARRIER, 0, 0);
            21'hF72: r = m(K_VOWEL, "i", 0);
            21'hF73: r = m(K_VOWEL, 32'h12B, 0);
            21'hF74: r = m(K_VOWEL, "u", 0);
            21'hF75: r = m(K_VOWEL, 32'h16B, 0);
            21'hF7A: r = m(K_VOWEL, "e", 0);
            21'hF7B: r = m(K_VOWEL, "a", "i");
            21'hF7C: r = m(K_VOWEL, "o", 0);
            21'hF7D: r = m(K_VOWEL, "a", "u");
            21'hF7E: r = m(K_MARK, 32'h1E43, 0);
            21'hF7F: r = m(K_MARK, 32'h1E25, 0);
            21'hF83: r = m(K_MARK, "~", 0);
            21'hF90: r = m(K_SUB, "k", 0);
            21'hF91: r = m(K_SUB, "k", "h");
            21'hF92: r = m(K_SUB, "g", 0);
            21'hF93: r = m(K_SUB, "g", "h");
            21'hF94: r = m(K_SUB, 32'h1E45, 0);
            21'hF95: r = m(K_SUB, "c", 0);
            21'hFA9: r = m(K_SUB, "c", 0);
            21'hF96: r = m(K_SUB, "c", "h");
            21'hFAA: r = m(K_SUB, "c", "h");
            21'hFAB: r = m(K_SUB, "j", 0);
            21'hF99: r = m(K_SUB, 32'hF1, 0);
            21'hF9A: r = m(K_SUB, 32'h1E6D, 0);
            21'hF9B: r = m(K_SUB, 32'h1E6D, "h");
            21'hF9C: r = m(K_SUB, 32'h1E0D, 0);
            21'hF9E: r = m(K_SUB, 32'h1E47, 0);
            21'hF9F: r = m(K_SUB, "t", 0);
            21'hFA0: r = m(K_SUB, "t", "h");
            21'hFA1: r = m(K_SUB, "d", 0);
            21'hFA2: r = m(K_SUB, "d", "h");
            21'hFA3: r = m(K_SUB, "n", 0);
            21'hFA4: r = m(K_SUB, "p", 0);
            21'hFA5: r = m(K_SUB, "p", "h");
            21'hFA6: r = m(K_SUB, "b", 0);
            21'hFA7: r = m(K_SUB, "b", "h");
            21'hFA8: r = m(K_SUB, "m", 0);
            21'hFB1: r = m(K_SUB, "y", 0);
            21'hFAD: r = m(K_SUB, "v", 0);
            21'hFB4: r = m(K_SUB, 32'h15B, 0);
            21'hFB5: r = m(K_SUB, 32'h1E63, 0);
            21'hFB7: r = m(K_SUB, "h", 0);
            default: r = m(K_UNKNOWN, 0, 0);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/syllabic_script_transliterator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// syllabic_script_transliterator: script code points to Latin code points
// Front classifier feeding a burst queue and a character serializer.
// ----------------------------------------------------------------------------
// One input transaction is accepted per cycle while the two-entry burst queue
// has room; each emits 0 to 10 characters, one per output cycle while the
// output is ready, so the sustained rate is set by the serializer.
module syllabic_script_transliterator
    import sst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [20:0] code_point, zero pad
    input  wire logic        s_axis_tuser,   // end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [20:0] out_char, zero pad
    output logic             m_axis_tlast    // last_of_run
);

    logic           b_valid, b_ready;
    burst_t         b_data;
    logic [CpW-1:0] oc;

    sst_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .code_point(s_axis_tdata[CpW-1:0]), .end_of_text(s_axis_tuser),
        .b_valid(b_valid), .b_ready(b_ready), .b_data(b_data)
    );

    sst_back u_back (
        .clk(clk), .rst_n(rst_n),
        .b_valid(b_valid), .b_ready(b_ready), .b_data(b_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_char(oc), .last_of_run(m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, oc};

endmodule
`default_nettype wire

// File: hw/rtl/sst_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sst_front: classifier and prefix resolver
// Accepts one code point per transaction, updates the vowel/prefix state and
// builds the burst of output characters that the item causes.
// ----------------------------------------------------------------------------
module sst_front
    import sst_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [CpW-1:0]   code_point,
    input  wire logic             end_of_text,
    output logic                  b_valid,
    input  wire logic             b_ready,
    output burst_t                b_data
);

    logic       vp_reg, vp_next;
    logic [3:0] pre_reg, pre_next;
    logic       bv_reg;
    burst_t     bd_reg, bd_next;
    logic       take;

    // Burst holds an item whose results may be empty; empty ones are dropped.
    assign in_ready = !bv_reg || b_ready;
    assign take     = in_valid && in_ready;
    assign b_valid  = bv_reg;
    assign b_data   = bd_reg;

    always_comb
    begin
        logic [3:0]      p;
        logic [1:0]      g;
        logic            waa;
        logic            done;
        logic            rest;
        logic            fr;
        logic            st;
        logic [CpW-1:0]  v;
        map_t            e;
        logic [3:0]      d;
        logic [23:0]     cpx;
        vp_next  = vp_reg;
        pre_next = P_NONE;
        bd_next  = '0;
        p        = pre_reg;
        g        = 2'(p - 4'd1 >> 1);
        waa      = !p[0];
        done     = 1'b0;
        rest     = 1'b0;
        fr       = 1'b0;
        v        = '0;
        e        = lookup(code_point);
        st       = 1'b0;
        cpx      = {3'b000, code_point};

        if (p >= 4'd1 && p <= 4'd8) begin
            if (!end_of_text && code_point == 21'hF80) begin
                v = g[0] ? (waa ? 21'h1E39 : 21'h1E37) : (waa ? 21'h1E5D : 21'h1E5B);
                bd_next.ch[bd_next.n] = v;
                bd_next.n = bd_next.n + 1'b1;
                vp_next = 1'b0;
                done = 1'b1;
            end else if (!waa && !end_of_text && code_point == 21'hF71) begin
                pre_next = p + 4'd1;
                done = 1'b1;
            end else begin
                if (!g[1]) begin
                    if (vp_next) begin
                        bd_next.ch[bd_next.n] = 21'h61;
                        bd_next.n = bd_next.n + 1'b1;
                    end
                    vp_next = 1'b1;
                end
                bd_next.ch[bd_next.n] = g[0] ? 21'h6C : 21'h72;
                bd_next.n = bd_next.n + 1'b1;
                rest = 1'b1;
            end
        end else begin
            rest = 1'b1;
        end

        if (rest && !done) begin
            if ((p == P_AA) || (p >= 4'd1 && p <= 4'd8 && waa)) begin
                if (!end_of_text && code_point == 21'hF72) begin
                    bd_next.ch[bd_next.n] = 21'h12B;
                    bd_next.n = bd_next.n + 1'b1;
                end else if (!end_of_text && code_point == 21'hF74) begin
                    bd_next.ch[bd_next.n] = 21'h16B;
                    bd_next.n = bd_next.n + 1'b1;
                end else begin
                    bd_next.ch[bd_next.n] = 21'h101;
                    bd_next.n = bd_next.n + 1'b1;
                    fr = !end_of_text;
                end
                vp_next = 1'b0;
            end else begin
                fr = !end_of_text;
            end
        end

        if (fr) begin
            case (code_point)
                21'hF62: pre_next = 4'd1;
                21'hF63: pre_next = 4'd3;
                21'hFB2: pre_next = 4'd5;
                21'hFB3: pre_next = 4'd7;
                21'hF71: pre_next = P_AA;
                default:
                begin
                    case (e.kind)
                        K_CONS, K_MARK, K_PUNCT:
                        begin
                            if (vp_next) begin
                                bd_next.ch[bd_next.n] = 21'h61;
                                bd_next.n = bd_next.n + 1'b1;
                            end
                            vp_next = (e.kind == K_CONS);
                        end
                        K_VOWEL:   vp_next = 1'b0;
                        K_CARRIER: vp_next = 1'b1;
                        default:   vp_next = vp_next;
                    endcase
                    if (e.kind == K_UNKNOWN) begin
                        for (int i = 5; i >= 0; i--) begin
                            d = cpx[i*4 +: 4];
                            if (d != 4'd0 || st || i == 0) begin
                                bd_next.ch[bd_next.n] = (d < 4'd10) ?
                                    CpW'(8'h30 + 8'(d)) : CpW'(8'h57 + 8'(d));
                                bd_next.n = bd_next.n + 1'b1;
                                st = 1'b1;
                            end
                        end
                        bd_next.ch[bd_next.n] = 21'h20;
                        bd_next.n = bd_next.n + 1'b1;
                    end else if (e.kind != K_CARRIER) begin
                        bd_next.ch[bd_next.n] = e.c0;
                        bd_next.n = bd_next.n + 1'b1;
                        if (e.c1 != '0) begin
                            bd_next.ch[bd_next.n] = e.c1;
                            bd_next.n = bd_next.n + 1'b1;
                        end
                    end
                end
            endcase
        end

        if (end_of_text) begin
            bd_next.ch[bd_next.n] = 21'h0A;
            bd_next.n = bd_next.n + 1'b1;
            vp_next = 1'b0;
            pre_next = P_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vp_reg  <= 1'b0;
            pre_reg <= P_NONE;
            bv_reg  <= 1'b0;
        end else begin
            if (take) begin
                vp_reg  <= vp_next;
                pre_reg <= pre_next;
                bv_reg  <= (bd_next.n != '0);
            end else if (b_ready) begin
                bv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            bd_reg <= bd_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/sst_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sst_back: burst serializer
// Two-entry queue of bursts and an output register that sends one character
// per transaction, marking the last of each burst.
// ----------------------------------------------------------------------------
module sst_back
    import sst_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             b_valid,
    output logic                  b_ready,
    input  wire burst_t           b_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [CpW-1:0]        out_char,
    output logic                  last_of_run
);

    burst_t          q_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic [CntW-1:0] idx_reg;
    logic            ov_reg;
    logic [CpW-1:0]  oc_reg;
    logic            ol_reg;
    logic            load, pop, push;
    burst_t          head;

    assign head        = q_reg[rp_reg];
    assign b_ready     = (cnt_reg != 2'd2);
    assign push        = b_valid && b_ready;
    assign load        = (cnt_reg != 2'd0) && (!ov_reg || out_ready);
    assign pop         = load && (idx_reg + 1'b1 == head.n);
    assign out_valid   = ov_reg;
    assign out_char    = oc_reg;
    assign last_of_run = ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
            if (load) idx_reg <= pop ? '0 : idx_reg + 1'b1;
            if (load) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) q_reg[wp_reg] <= b_data;
        if (load) begin
            oc_reg <= head.ch[idx_reg];
            ol_reg <= pop;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/sst_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sst_checker: port-level checks for the transliterator
// Output stream sanity over time.
// ----------------------------------------------------------------------------
module sst_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:21] == 3'b000)
        else $error("pad bits set");

    a_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[20:0] != 21'd0)
        else $error("null character emitted");

endmodule

bind syllabic_script_transliterator sst_checker u_chk (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
